[src/bltd_pkg.sv]
// Package: shared command and status types for the byte-level token text decoder.
`default_nettype none
package bltd_pkg;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // take the accepted item into the byte buffer
      logic step;   // run one parse step on the buffer front
   } bltd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic finish;    // the current step ends the work on this item
      logic need_out;  // the current step pushes a held byte to the output register
      logic out_free;  // the output register can take a byte this cycle
   } bltd_sts_type;

   localparam int unsigned BufDepth = 4;
   localparam int unsigned CntWidth = 3;

endpackage
`default_nettype wire

[src/bltd_chan_if.sv]
// Interfaces: request and response channels of the byte-level token text decoder.
`default_nettype none
interface bltd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       token_end;

   modport source (output valid, output text_byte, output token_end, input ready);
   modport sink   (input valid, input text_byte, input token_end, output ready);
endinterface

interface bltd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface
`default_nettype wire

[src/bltd_datapath.sv]
// Datapath: byte buffer, UTF-8 parse step, codepoint mapping, held byte and output register.
`default_nettype none
module bltd_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bltd_pkg::bltd_cmd_type cmd,
   output bltd_pkg::bltd_sts_type    sts,
   input  wire logic [7:0]           req_text_byte,
   input  wire logic                 req_token_end,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_run_last
);

   localparam int unsigned CpWidth = 21;

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] n;
      if (b[7] == 1'b0)              n = 3'd1;
      else if (b[7:5] == 3'b110)     n = 3'd2;
      else if (b[7:4] == 4'b1110)    n = 3'd3;
      else if (b[7:3] == 5'b11110)   n = 3'd4;
      else                           n = 3'd1;
      return n;
   endfunction

   function automatic logic is_direct(input logic [7:0] v);
      return (v >= 8'h21 && v <= 8'h7e) || (v >= 8'ha1 && v <= 8'hac) || (v >= 8'hae);
   endfunction

   logic [7:0]                  buf_ff [bltd_pkg::BufDepth];
   logic [bltd_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic [1:0]                  left_ff, left_in;
   logic                        raw_ff, raw_in;
   logic                        tend_ff;
   logic                        hold_valid_ff, hold_valid_in;
   logic [7:0]                  hold_byte_ff;
   logic                        out_valid_ff, out_valid_in;
   logic [7:0]                  out_byte_ff;
   logic                        out_last_ff;

   logic [7:0]         lead;
   logic [2:0]         n;
   logic [3:1]         cont_ok;
   logic [1:0]         bad;
   logic [CpWidth-1:0] cp;
   logic               map_ok;
   logic [7:0]         map_byte;
   logic               emit;
   logic               finish;
   logic [7:0]         emit_byte;
   logic               shift_en;
   logic               push;

   assign lead = buf_ff[0];
   assign n    = seq_len(lead);

   always_comb begin
      for (int i = 1; i < bltd_pkg::BufDepth; i++) begin
         cont_ok[i] = (buf_ff[i][7:6] == 2'b10);
      end
   end

   // First continuation byte that is not 10xxxxxx, zero when all are good.
   always_comb begin
      bad = 2'd0;
      if (!cont_ok[1])                     bad = 2'd1;
      else if (n >= 3'd3 && !cont_ok[2])   bad = 2'd2;
      else if (n == 3'd4 && !cont_ok[3])   bad = 2'd3;
   end

   always_comb begin
      unique case (n)
         3'd2:    cp = {10'd0, lead[4:0], buf_ff[1][5:0]};
         3'd3:    cp = {5'd0, lead[3:0], buf_ff[1][5:0], buf_ff[2][5:0]};
         3'd4:    cp = {lead[2:0], buf_ff[1][5:0], buf_ff[2][5:0], buf_ff[3][5:0]};
         default: cp = {13'd0, lead};
      endcase
   end

   // Map a codepoint back to its original byte; 256..323 hold the non-printable bytes.
   always_comb begin
      map_ok   = 1'b0;
      map_byte = cp[7:0];
      if (cp[CpWidth-1:9] == '0) begin
         if (!cp[8]) begin
            map_ok = is_direct(cp[7:0]);
         end else if (cp[7:0] < 8'd33) begin
            map_ok = 1'b1;
         end else if (cp[7:0] < 8'd67) begin
            map_ok   = 1'b1;
            map_byte = cp[7:0] + 8'd94;
         end else if (cp[7:0] == 8'd67) begin
            map_ok   = 1'b1;
            map_byte = 8'had;
         end
      end
   end

   // One parse step: emit at most one byte and drop the front byte, unless the step finishes the item.
   always_comb begin
      emit      = 1'b0;
      finish    = 1'b0;
      emit_byte = lead;
      shift_en  = 1'b0;
      left_in   = left_ff;
      raw_in    = raw_ff;
      priority if (left_ff != 2'd0) begin
         // walk the rest of a sequence: pass raw bytes or drop consumed ones
         shift_en = 1'b1;
         emit     = raw_ff;
         left_in  = left_ff - 2'd1;
      end else if (cnt_ff == '0) begin
         finish = 1'b1;
      end else if (n == 3'd1) begin
         emit     = 1'b1;
         shift_en = 1'b1;
      end else if (cnt_ff < n) begin
         // sequence incomplete: at token end the lead goes alone and the rest is parsed again, else wait
         if (tend_ff) begin
            emit     = 1'b1;
            shift_en = 1'b1;
         end else begin
            finish = 1'b1;
         end
      end else if (bad != 2'd0) begin
         emit     = 1'b1;
         shift_en = 1'b1;
         left_in  = bad;
         raw_in   = 1'b0;
      end else if (map_ok) begin
         emit      = 1'b1;
         emit_byte = map_byte;
         shift_en  = 1'b1;
         left_in   = 2'(n - 3'd1);
         raw_in    = 1'b0;
      end else begin
         emit     = 1'b1;
         shift_en = 1'b1;
         left_in  = 2'(n - 3'd1);
         raw_in   = 1'b1;
      end
   end

   assign sts.finish   = finish;
   assign sts.need_out = hold_valid_ff && (emit || finish);
   assign sts.out_free = !out_valid_ff || rsp_ready;

   assign push = cmd.step && sts.need_out;

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = cnt_ff + 3'd1;
      end else if (cmd.step && shift_en) begin
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (cmd.step && emit) begin
         hold_valid_in = 1'b1;
      end else if (cmd.step && finish) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (push) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         left_ff       <= 2'd0;
         raw_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
         if (cmd.step) begin
            left_ff <= left_in;
            raw_ff  <= raw_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         buf_ff[cnt_ff[1:0]] <= req_text_byte;
         tend_ff             <= req_token_end;
      end else if (cmd.step && shift_en) begin
         for (int i = 0; i < bltd_pkg::BufDepth - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
      end
      if (cmd.step && emit) begin
         hold_byte_ff <= emit_byte;
      end
      if (push) begin
         out_byte_ff <= hold_byte_ff;
         out_last_ff <= finish;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = out_last_ff;

   // A new byte always finds a free buffer slot.
   a_load_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> cnt_ff < 3'd4)
      else $error("byte buffer overflow on load");

   // Never end an item while a sequence walk is still in progress.
   a_no_finish_mid_walk: assert property (@(posedge clock) disable iff (reset)
      left_ff != 2'd0 |-> !finish)
      else $error("item finished during sequence walk");

   // A push never overwrites a byte the sink has not taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> (!out_valid_ff || rsp_ready))
      else $error("output register overwritten");

   // The held byte is always flushed at the end of an item.
   a_hold_flushed: assert property (@(posedge clock) disable iff (reset)
      cmd.step && finish |=> !hold_valid_ff)
      else $error("held byte left after item end");

endmodule
`default_nettype wire

[src/bltd_ctrl.sv]
// Controller: accept/parse state machine of the byte-level token text decoder.
`default_nettype none
module bltd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output bltd_pkg::bltd_cmd_type      cmd,
   input  wire bltd_pkg::bltd_sts_type sts
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   assign req_ready = ready_ff;
   assign cmd.load  = req_valid && ready_ff;
   // stall a step that must push while the output register is still full
   assign cmd.step  = (state_ff == ST_RUN) && (!sts.need_out || sts.out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff <= ST_RUN;
                  ready_ff <= 1'b0;
               end
            end
            ST_RUN: begin
               if (cmd.step && sts.finish) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

[src/byte_level_token_text_decoder.sv]
// Top level: byte-level token text decoder, UTF-8 bytes in, original bytes out.
//
//   channel    dir   payload                        handshake
//   req_chan   in    text_byte[7:0], token_end      valid/ready
//   rsp_chan   out   out_byte[7:0],  run_last       valid/ready
//
// Each accepted item is followed by parse steps, each dropping one buffered byte,
// and by a closing step that ends the item; no new byte is accepted until then.
// One parse step runs per cycle on the 4-byte buffer unless a push must stall it.
// Synchronous reset empties the buffer and drops the held and output bytes.
// A full output register stalls the parse steps that need to push a byte.
// Each output byte is held until the next emitting or closing step, so run_last can be marked.
`default_nettype none
module byte_level_token_text_decoder (
   input  wire logic clock,
   input  wire logic reset,
   bltd_req_if.sink   req_chan,
   bltd_rsp_if.source rsp_chan
);

   bltd_pkg::bltd_cmd_type cmd;
   bltd_pkg::bltd_sts_type sts;

   bltd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bltd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_text_byte (req_chan.text_byte),
      .req_token_end (req_chan.token_end),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_out_byte  (rsp_chan.out_byte),
      .rsp_run_last  (rsp_chan.run_last)
   );

endmodule
`default_nettype wire

[bench/bltd_checker.sv]
// Checker: predicts the decoded output bytes of each accepted text byte and compares them.
`timescale 1ns / 100ps
module bltd_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_text_byte,
   input  wire logic       req_token_end,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_run_last,
   output int              mismatch_count,
   output int              awaited_count
);

   localparam int unsigned RemapBase  = 256;
   localparam int unsigned RemapLimit = 512;
   localparam int unsigned LowCtrlCnt = 33;   // bytes 0x00..0x20
   localparam int unsigned MidCtrlEnd = 67;   // bytes 0x7F..0xA0 follow them
   localparam int unsigned MaxRun     = 4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } decoded_byte_type;

   logic [7:0]       partial_seq[$];
   decoded_byte_type awaited_bytes[$];
   decoded_byte_type oldest;

   function automatic int unsigned utf8_length(input logic [7:0] lead);
      if (!lead[7]) return 1;
      if (lead[7:5] == 3'b110) return 2;
      if (lead[7:4] == 4'b1110) return 3;
      if (lead[7:3] == 5'b11110) return 4;
      return 1;
   endfunction

   function automatic bit passes_direct(input int unsigned v);
      return (v >= 'h21 && v <= 'h7e) || (v >= 'ha1 && v <= 'hac) || (v >= 'hae && v <= 'hff);
   endfunction

   // Undo the byte-to-codepoint remap; return 0 when the codepoint has no original byte.
   function automatic bit original_byte(input int unsigned cp, output logic [7:0] ob);
      int unsigned k;
      ob = '0;
      if (cp >= RemapLimit) return 0;
      if (cp < RemapBase) begin
         ob = cp[7:0];
         return passes_direct(cp);
      end
      k = cp - RemapBase;
      if (k < LowCtrlCnt) begin
         ob = k[7:0];
         return 1;
      end
      if (k < MidCtrlEnd) begin
         ob = 8'(k - LowCtrlCnt + 'h7f);
         return 1;
      end
      if (k == MidCtrlEnd) begin
         ob = 8'had;
         return 1;
      end
      return 0;
   endfunction

   task automatic decode_text_byte(input logic [7:0] text_byte, input logic token_end);
      logic [7:0]       run_bytes[$];
      logic [7:0]       lead;
      logic [7:0]       mapped;
      int unsigned      seq_len;
      int unsigned      bad_at;
      int unsigned      cp;
      bit               parsing;
      decoded_byte_type item;
      if (partial_seq.size() >= bltd_pkg::BufDepth) partial_seq.delete();
      partial_seq = {partial_seq, text_byte};
      parsing = 1;
      while (parsing && partial_seq.size() != 0) begin
         lead = partial_seq[0];
         seq_len = utf8_length(lead);
         if (seq_len == 1) begin
            run_bytes = {run_bytes, lead};
            void'(partial_seq.pop_front());
         end else if (partial_seq.size() < seq_len) begin
            // flush the lone lead at a token end, else wait for more bytes
            if (token_end) begin
               run_bytes = {run_bytes, lead};
               void'(partial_seq.pop_front());
            end else begin
               parsing = 0;
            end
         end else begin
            cp = (seq_len == 2) ? 32'(lead[4:0]) :
                 (seq_len == 3) ? 32'(lead[3:0]) : 32'(lead[2:0]);
            bad_at = 0;
            for (int unsigned i = 1; i < seq_len && bad_at == 0; i++) begin
               if (partial_seq[i][7:6] != 2'b10) bad_at = i;
               else cp = (cp << 6) | 32'(partial_seq[i][5:0]);
            end
            if (bad_at != 0) begin
               // emit the lead, drop everything up to and including the bad byte
               run_bytes = {run_bytes, lead};
               repeat (bad_at + 1) void'(partial_seq.pop_front());
            end else if (original_byte(cp, mapped)) begin
               run_bytes = {run_bytes, mapped};
               repeat (seq_len) void'(partial_seq.pop_front());
            end else begin
               repeat (seq_len) run_bytes = {run_bytes, partial_seq.pop_front()};
            end
         end
      end
      while (run_bytes.size() > MaxRun) void'(run_bytes.pop_back());
      foreach (run_bytes[i]) begin
         item.out_byte = run_bytes[i];
         item.run_last = (i == run_bytes.size() - 1);
         awaited_bytes = {awaited_bytes, item};
      end
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         partial_seq.delete();
         awaited_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_bytes.size() == 0) begin
               report_mismatch("output item with none awaited", rsp_out_byte, 0);
            end else begin
               oldest = awaited_bytes.pop_front();
               if (rsp_out_byte !== oldest.out_byte)
                  report_mismatch("out_byte", rsp_out_byte, oldest.out_byte);
               if (rsp_run_last !== oldest.run_last)
                  report_mismatch("run_last", rsp_run_last, oldest.run_last);
            end
         end
         if (req_valid && req_ready) decode_text_byte(req_text_byte, req_token_end);
      end
      awaited_count <= awaited_bytes.size();
   end

endmodule

[bench/testbench.sv]
// Testbench top: clock, reset, token byte stimulus and verdict for the text decoder.
`timescale 1ns / 100ps
module testbench;

   localparam int unsigned RandomItems = 185;
   localparam int unsigned IdleLimit   = 3000;
   localparam int unsigned HoldCycles  = 90;
   localparam int unsigned DrainCycles = 20;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       token_end;
   } text_item_type;

   logic          clock;
   logic          reset;
   int            mismatch_count;
   int            awaited_count;
   int unsigned   sent_count = 0;
   int unsigned   idle_cycles = 0;
   int unsigned   directed_count;
   text_item_type text_items[$];
   logic [7:0]    token_bytes[$];

   bltd_req_if req_chan ();
   bltd_rsp_if rsp_chan ();

   byte_level_token_text_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bltd_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_text_byte  (req_chan.text_byte),
      .req_token_end  (req_chan.token_end),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_out_byte   (rsp_chan.out_byte),
      .rsp_run_last   (rsp_chan.run_last),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Move the gathered token bytes to the stimulus, marking the last one.
   function automatic void close_token();
      text_item_type item;
      foreach (token_bytes[i]) begin
         item.text_byte = token_bytes[i];
         item.token_end = (i == token_bytes.size() - 1);
         text_items = {text_items, item};
      end
      token_bytes.delete();
   endfunction

   function automatic void add_token(input logic [39:0] bytes, input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         token_bytes = {token_bytes, bytes[8 * (count - 1 - i) +: 8]};
      close_token();
   endfunction

   function automatic void add_sequence();
      logic [20:0] cp;
      logic [7:0]  noise;
      int unsigned first;
      int unsigned kind;
      first = token_bytes.size();
      kind = $urandom_range(0, 9);
      cp = '0;
      case (kind)
         0, 1, 2: cp = 21'($urandom_range(0, 'h7f));
         3, 4:    cp = 21'($urandom_range(256, 323));
         5:       cp = 21'($urandom_range('h80, 'h7ff));
         6:       cp = 21'($urandom_range('h800, 'hffff));
         7:       cp = 21'($urandom_range('h10000, 'h10ffff));
         default: cp = '0;
      endcase
      if (kind == 8) begin
         noise = 8'($urandom_range(0, 255));
         token_bytes = {token_bytes, noise};
      end else if (kind == 9) begin
         // overlong two-byte form
         token_bytes = {token_bytes, 8'hc0 | 8'($urandom_range(0, 1))};
         token_bytes = {token_bytes, 8'h80 | 8'($urandom_range(0, 63))};
      end else if (cp < 'h80) begin
         token_bytes = {token_bytes, cp[7:0]};
      end else if (cp < 'h800) begin
         token_bytes = {token_bytes, {3'b110, cp[10:6]}};
         token_bytes = {token_bytes, {2'b10, cp[5:0]}};
      end else if (cp < 'h10000) begin
         token_bytes = {token_bytes, {4'b1110, cp[15:12]}};
         token_bytes = {token_bytes, {2'b10, cp[11:6]}};
         token_bytes = {token_bytes, {2'b10, cp[5:0]}};
      end else begin
         token_bytes = {token_bytes, {5'b11110, cp[20:18]}};
         token_bytes = {token_bytes, {2'b10, cp[17:12]}};
         token_bytes = {token_bytes, {2'b10, cp[11:6]}};
         token_bytes = {token_bytes, {2'b10, cp[5:0]}};
      end
      // corrupt a continuation byte now and then
      if (token_bytes.size() - first > 1 && $urandom_range(0, 7) == 0) begin
         noise = 8'($urandom_range(0, 255));
         token_bytes[first + $urandom_range(1, token_bytes.size() - first - 1)] = noise;
      end
   endfunction

   function automatic void add_random_token();
      int unsigned keep;
      repeat ($urandom_range(1, 4)) add_sequence();
      // end the token early, often inside a sequence
      if (token_bytes.size() > 1 && $urandom_range(0, 5) == 0) begin
         keep = $urandom_range(1, token_bytes.size() - 1);
         while (token_bytes.size() > keep) void'(token_bytes.pop_back());
      end
      close_token();
   endfunction

   task automatic drive_items();
      int unsigned burst;
      int unsigned gap;
      while (text_items.size() != 0) begin
         burst = $urandom_range(1, 16);
         while (burst != 0 && text_items.size() != 0) begin
            req_chan.valid     <= 1'b1;
            req_chan.text_byte <= text_items[0].text_byte;
            req_chan.token_end <= text_items[0].token_end;
            do @(posedge clock); while (!req_chan.ready);
            void'(text_items.pop_front());
            sent_count++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   // Receiver: runs of steady, sparse, dense or toggling ready, plus one long hold-off.
   initial begin
      int unsigned mode;
      int unsigned span;
      bit          held_off;
      held_off = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held_off && sent_count >= 40) begin
            held_off = 1;
            rsp_chan.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(4, 40);
         repeat (span) begin
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= ~rsp_chan.ready;
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.text_byte <= '0;
      req_chan.token_end <= 1'b0;

      add_token(40'h00_7f_80_f8_ff, 5);  // ASCII extremes and stray bytes
      add_token(40'hc3_a9, 2);           // printable codepoint maps to itself
      add_token(40'hc5_83_c5_84, 4);     // last remapped codepoint, then one past it
      add_token(40'he2_82_ac, 3);        // three-byte codepoint passes through raw
      add_token(40'hf0_9f_98_80, 4);     // four-byte codepoint passes through raw
      add_token(40'hc0_a1, 2);           // overlong form of a printable byte
      add_token(40'he2_82, 2);           // token ends inside a sequence
      add_token(40'he2_41_42, 3);        // bad continuation, rest parsed again
      directed_count = text_items.size();
      while (text_items.size() < directed_count + RandomItems) add_random_token();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      drive_items();

      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
